### rtl/core/npvw_pkg.sv
// shared constants, types and state codes for the nearest prior value search
package npvw_pkg;

  // history size and derived widths
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int VAL_W   = 32;
  localparam int WIN_W   = 31;
  localparam int IDX_W   = 10;
  localparam int PRIOR_W = 11;

  // no-match marker for prior_index
  localparam logic [PRIOR_W-1:0] PRIOR_NONE = '1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // history memory access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/core/npvw_hist_mem.sv
// history value memory, one write and one registered read per cycle
module npvw_hist_mem (
  input  logic                       clk,
  input  npvw_pkg::mem_req_t         req,
  output logic [npvw_pkg::VAL_W-1:0] rdata
);
  import npvw_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### rtl/core/nearest_prior_in_value_window.sv
// top level: backward history scan for the nearest prior smaller value in a window
// For each value v the block returns the index of the most recent earlier item of
// the current sequence whose value u satisfies u < v and v - u <= window, or -1.
// An item with start_of_set high opens a new sequence at index 0. Once DEPTH items
// are stored, further items answer -1 with overflow set and item_index 0.
// After acceptance an item scans the entries already in its sequence, newest first;
// a match ends the scan early, and an overflow item skips the scan. A result is handed
// over only once the output register is free, so a result still held there holds back
// the next handover.
// The scan reads one history entry per cycle from the single read port of the
// history memory and compares it in one shared 33-bit subtract and compare unit.
// The input is stalled until the result is handed to the output register; the
// output register then holds it while the next transaction is taken.
module nearest_prior_in_value_window (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [npvw_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_start_of_set,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [npvw_pkg::IDX_W-1:0]          out_item_index,
  output logic signed [npvw_pkg::PRIOR_W-1:0] out_prior_index,
  output logic                                out_overflow,
  // window register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [npvw_pkg::WIN_W-1:0]          cfg_window
);
  import npvw_pkg::*;

  // registers
  state_t              state_r, state_nxt;
  logic [WIN_W-1:0]    window_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [VAL_W-1:0]    value_r, value_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [PRIOR_W-1:0]  prior_r, prior_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [PRIOR_W-1:0]  out_prior_r, out_prior_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // combinational helpers
  logic                in_fire;
  logic                out_fire;
  logic [CNT_W-1:0]    base_cnt;
  logic [CNT_W-1:0]    rem_dec;
  logic [VAL_W:0]      diff;
  logic                hit;
  mem_req_t            mem_req;
  logic [VAL_W-1:0]    mem_q;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign base_cnt  = in_start_of_set ? '0 : cnt_r;
  assign rem_dec   = rem_r - CNT_W'(1);

  // shared compare unit: exact 33-bit v - u, then sign, zero and window test
  assign diff = {value_r[VAL_W-1], value_r} - {mem_q[VAL_W-1], mem_q};
  assign hit  = pend_r && !diff[VAL_W] && (diff != '0)
                && (diff[VAL_W-1:0] <= {1'b0, window_r});

  // history memory
  npvw_hist_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_q)
  );

  // window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_window;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    pend_idx_r  <= pend_idx_nxt;
    value_r     <= value_nxt;
    idx_r       <= idx_nxt;
    prior_r     <= prior_nxt;
    ovf_r       <= ovf_nxt;
    out_idx_r   <= out_idx_nxt;
    out_prior_r <= out_prior_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    value_nxt     = value_r;
    idx_nxt       = idx_r;
    prior_nxt     = prior_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_prior_nxt = out_prior_r;
    out_ovf_nxt   = out_ovf_r;
    mem_req       = '0;
    mem_req.waddr = base_cnt[ADDR_W-1:0];
    mem_req.wdata = in_value;
    mem_req.raddr = rem_dec[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          value_nxt = in_value;
          pend_nxt  = 1'b0;
          prior_nxt = PRIOR_NONE;
          if (base_cnt == CNT_W'(DEPTH)) begin
            // history full: fixed overflow answer, nothing stored
            ovf_nxt   = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            // store the item now, scan the entries below it
            mem_req.we = 1'b1;
            ovf_nxt    = 1'b0;
            idx_nxt    = base_cnt[ADDR_W-1:0];
            rem_nxt    = base_cnt;
            cnt_nxt    = base_cnt + CNT_W'(1);
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          prior_nxt = PRIOR_W'(pend_idx_r);
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else if (rem_r != '0) begin
          // next older entry
          mem_req.re   = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rem_dec[ADDR_W-1:0];
          rem_nxt      = rem_dec;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_fire) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(idx_r);
          out_prior_nxt = prior_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_item_index  = out_idx_r;
  assign out_prior_index = out_prior_r;
  assign out_overflow    = out_ovf_r;

  // stored count never passes the history size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("item count above history size");

  // an entry under compare is always older than the current item
  a_scan_older: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_r) |-> (pend_idx_r < idx_r))
    else $error("scan reached an entry not older than the item");

  // an overflow transaction carries the fixed answer
  a_ovf_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_prior_r == PRIOR_NONE && out_idx_r == '0))
    else $error("overflow result with a match or nonzero index");

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SCAN || state_r == ST_DONE))
    else $error("accepted transaction did not start");

endmodule

### test/tb_nearest_prior_in_value_window.sv
// testbench for the nearest prior smaller value search with a scoreboard and random traffic
module tb_nearest_prior_in_value_window;
  import npvw_pkg::*;

  localparam int RANDOM_ITEMS = 580;
  localparam int CYCLE_LIMIT  = 4_000_000;

  // one lookup answer as seen on the result channel
  typedef struct packed {
    logic [IDX_W-1:0]   item_index;
    logic [PRIOR_W-1:0] prior_index;
    logic               overflow;
  } lookup_result_t;

  // mirrors the history and window, queues the answers still to come
  class prior_match_scoreboard;
    logic [VAL_W-1:0] history [DEPTH];
    int unsigned      stored;
    logic [WIN_W-1:0] window;
    lookup_result_t   awaited [$];
    int unsigned      errors;

    function new();
      stored = 0;
      window = '0;
      errors = 0;
    endfunction

    // predict the answer for an accepted input transaction
    function void note_input(logic signed [VAL_W-1:0] value, logic start);
      lookup_result_t r;
      longint v;
      longint u;
      int i;
      v = value;
      if (start) stored = 0;
      if (stored >= DEPTH) begin
        // full history: fixed answer, item dropped
        r.item_index  = '0;
        r.prior_index = PRIOR_NONE;
        r.overflow    = 1'b1;
        awaited.push_back(r);
        return;
      end
      r.item_index  = stored[IDX_W-1:0];
      r.prior_index = PRIOR_NONE;
      r.overflow    = 1'b0;
      // newest first, difference taken exactly in 64 bits
      for (i = int'(stored) - 1; i >= 0; i--) begin
        u = $signed(history[i]);
        if (u < v && (v - u) <= longint'(window)) begin
          r.prior_index = i[PRIOR_W-1:0];
          break;
        end
      end
      history[stored] = value;
      stored++;
      awaited.push_back(r);
    endfunction

    // compare a result transaction with the oldest prediction
    function void check_result(lookup_result_t got);
      lookup_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result item_index %0d prior_index %0d overflow %0b",
                 $time, got.item_index, $signed(got.prior_index), got.overflow);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.item_index !== exp.item_index) begin
        $display("%0t: item_index expected %0d actual %0d",
                 $time, exp.item_index, got.item_index);
        errors++;
      end
      if (got.prior_index !== exp.prior_index) begin
        $display("%0t: prior_index expected %0d actual %0d",
                 $time, $signed(exp.prior_index), $signed(got.prior_index));
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t: overflow expected %0b actual %0b",
                 $time, exp.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [VAL_W-1:0]    in_value = '0;
  logic                       in_start_of_set = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [IDX_W-1:0]           out_item_index;
  logic signed [PRIOR_W-1:0]  out_prior_index;
  logic                       out_overflow;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [WIN_W-1:0]           cfg_window = '0;

  prior_match_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  bit stall_phase = 1'b0;
  int stall_left = 0;

  nearest_prior_in_value_window u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_start_of_set (in_start_of_set),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item_index  (out_item_index),
    .out_prior_index (out_prior_index),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_window      (cfg_window)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall pattern: short stalls, short runs, now and then a long calm run
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_phase = ~stall_phase;
      if (stall_phase) stall_left = $urandom_range(1, 8);
      else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(40, 120);
      else stall_left = $urandom_range(1, 10);
    end else begin
      stall_left--;
    end
    out_stall <= stall_phase;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_item_index, out_prior_index, out_overflow});
  end

  // one input transaction, then either keep the burst going or idle a while
  task automatic send_item(input logic signed [VAL_W-1:0] value, input logic start);
    in_valid        <= 1'b1;
    in_value        <= value;
    in_start_of_set <= start;
    do @(posedge clk); while (in_stall);
    sb.note_input(value, start);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  // hold off the sender until every answer is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // window write, only with the block idle
  task automatic write_window(input logic [WIN_W-1:0] w);
    wait_for_results();
    cfg_valid  <= 1'b1;
    cfg_window <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.window = w;
  endtask

  function automatic logic [WIN_W-1:0] pick_window();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return WIN_W'($urandom_range(1, 16));
      3:       return WIN_W'($urandom_range(17, 5000));
      default: return raw[WIN_W-1:0];
    endcase
  endfunction

  initial begin
    logic signed [VAL_W-1:0] value;
    logic start;
    int sent;
    int len;
    int mode;
    int span;
    int k;

    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // window still at reset zero, no start flag: nothing can match
    send_item(5, 1'b0);
    send_item(6, 1'b0);
    send_item(-7, 1'b0);

    // widest window: extremes of the value range and equal values
    write_window('1);
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(-1, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);

    // narrow window: edge of the window, gaps, restart mid stream
    write_window(WIN_W'(10));
    send_item(100, 1'b1);
    send_item(100, 1'b0);
    send_item(110, 1'b0);
    send_item(111, 1'b0);
    send_item(121, 1'b0);
    send_item(50, 1'b0);
    send_item(122, 1'b0);
    send_item(60, 1'b0);
    send_item(40, 1'b1);
    send_item(45, 1'b0);

    // fill the history past its end, each stored item after the first matching its predecessor
    write_window(WIN_W'(1));
    send_item(0, 1'b1);
    for (k = 1; k <= DEPTH + 2; k++) send_item(k, 1'b0);
    send_item(-5, 1'b0);
    send_item(3, 1'b1);
    send_item(4, 1'b0);

    // random sequences under changing windows
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0, 1:    write_window(pick_window());
        2:       wait_for_results();
        default: ;
      endcase
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
      mode = $urandom_range(0, 3);
      span = (mode == 2) ? $urandom_range(1, 20) : $urandom_range(1000, 100000);
      value = $urandom;
      for (k = 0; k < len; k++) begin
        if (mode == 0) value = $urandom;
        else if (mode == 1) value = $urandom_range(0, 15);
        else value = value + $signed($urandom_range(0, 2 * span)) - span;
        // mostly proper starts, sometimes a continued or broken sequence
        start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        send_item(value, start);
        sent++;
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### nearest_prior_in_value_window.f
rtl/core/npvw_pkg.sv
rtl/core/npvw_hist_mem.sv
rtl/core/nearest_prior_in_value_window.sv
test/tb_nearest_prior_in_value_window.sv
